// File: rtl/jet_pkg.sv
package jet_pkg;

  localparam int COORD_W = 32;
  localparam int ESC_W   = 31;
  localparam int OUT_W   = 10;
  localparam int PROD_W  = 2 * COORD_W;

  localparam logic signed [COORD_W-1:0] CONST_REAL_RST = -32'sd107374182;
  localparam logic signed [COORD_W-1:0] CONST_IMAG_RST = 32'sd161061274;
  localparam int                        LIMIT_RST      = 200;
  localparam logic [ESC_W-1:0]          ESC_SQ_RST     = 31'd603979776;

  typedef enum logic [1:0] {
    REG_CONST_REAL = 2'd0,
    REG_CONST_IMAG = 2'd1,
    REG_ITER_LIMIT = 2'd2,
    REG_ESC_SQUARE = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_TEST,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic upd;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic escaped;
    logic at_limit;
  } dp_sts_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [PROD_W-1:0] x
  );
    logic hi_same;
    hi_same = (&x[PROD_W-1:COORD_W-1]) | (~|x[PROD_W-1:COORD_W-1]);
    if (hi_same) begin
      return x[COORD_W-1:0];
    end else if (x[PROD_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/julia_escape_time_top.sv
// a point is loaded in ST_IDLE; each iteration then runs ST_MUL for the products and
// ST_TEST for the escape test and update; a point that escapes in ST_TEST, or reaches
// the iteration limit in ST_MUL, goes to ST_EMIT, which writes its result into the output
// register once it is free; one point at a time, the next one accepted in ST_IDLE again
// reset: synchronous active-low rst_n clears the controller and output valid and
// loads the configuration registers with their default values
module julia_escape_time_top #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [jet_pkg::COORD_W-1:0] in_start_real,
  input  logic signed [jet_pkg::COORD_W-1:0] in_start_imag,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [jet_pkg::OUT_W-1:0]   out_escape_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic        [1:0]                  cfg_index,
  input  logic        [jet_pkg::COORD_W-1:0] cfg_wdata
);

  logic signed [jet_pkg::COORD_W-1:0] const_real_r;
  logic signed [jet_pkg::COORD_W-1:0] const_imag_r;
  logic        [COUNT_BITS-1:0]       iter_limit_r;
  logic        [jet_pkg::ESC_W-1:0]   escape_sq_r;

  jet_pkg::dp_cmd_t cmd;
  jet_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_real_r <= jet_pkg::CONST_REAL_RST;
      const_imag_r <= jet_pkg::CONST_IMAG_RST;
      iter_limit_r <= COUNT_BITS'(jet_pkg::LIMIT_RST);
      escape_sq_r  <= jet_pkg::ESC_SQ_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jet_pkg::REG_CONST_REAL: const_real_r <= $signed(cfg_wdata);
        jet_pkg::REG_CONST_IMAG: const_imag_r <= $signed(cfg_wdata);
        jet_pkg::REG_ITER_LIMIT: iter_limit_r <= cfg_wdata[COUNT_BITS-1:0];
        jet_pkg::REG_ESC_SQUARE: escape_sq_r  <= cfg_wdata[jet_pkg::ESC_W-1:0];
        default: ;
      endcase
    end
  end

  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  jet_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_real   (in_start_real),
    .start_imag   (in_start_imag),
    .const_real   (const_real_r),
    .const_imag   (const_imag_r),
    .iter_limit   (iter_limit_r),
    .escape_sq    (escape_sq_r),
    .cmd          (cmd),
    .sts          (sts),
    .escape_count (out_escape_count)
  );

endmodule

// File: rtl/jet_ctrl.sv
module jet_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output jet_pkg::dp_cmd_t cmd,
  input  jet_pkg::dp_sts_t sts
);

  jet_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jet_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = jet_pkg::ST_MUL;
      end
      jet_pkg::ST_MUL: begin
        state_nxt = sts.at_limit ? jet_pkg::ST_EMIT : jet_pkg::ST_TEST;
      end
      jet_pkg::ST_TEST: begin
        state_nxt = sts.escaped ? jet_pkg::ST_EMIT : jet_pkg::ST_MUL;
      end
      jet_pkg::ST_EMIT: begin
        if (slot_free) state_nxt = jet_pkg::ST_IDLE;
      end
      default: state_nxt = jet_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      jet_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      jet_pkg::ST_MUL: begin
        cmd.mul = !sts.at_limit;
      end
      jet_pkg::ST_TEST: begin
        cmd.upd = !sts.escaped;
      end
      jet_pkg::ST_EMIT: begin
        cmd.emit = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  // result register valid: a new transaction may land as the old one leaves
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jet_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/jet_dp.sv
module jet_dp #(
  parameter int FRAC_BITS  = 28,
  parameter int COUNT_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [jet_pkg::COORD_W-1:0]  start_real,
  input  logic signed [jet_pkg::COORD_W-1:0]  start_imag,
  input  logic signed [jet_pkg::COORD_W-1:0]  const_real,
  input  logic signed [jet_pkg::COORD_W-1:0]  const_imag,
  input  logic        [COUNT_BITS-1:0]        iter_limit,
  input  logic        [jet_pkg::ESC_W-1:0]    escape_sq,
  input  jet_pkg::dp_cmd_t                    cmd,
  output jet_pkg::dp_sts_t                    sts,
  output logic        [jet_pkg::OUT_W-1:0]    escape_count
);

  localparam logic [jet_pkg::PROD_W-1:0] LO_MASK =
    (jet_pkg::PROD_W'(1) << FRAC_BITS) - jet_pkg::PROD_W'(1);

  logic signed [jet_pkg::COORD_W-1:0] re_r, re_nxt;
  logic signed [jet_pkg::COORD_W-1:0] im_r, im_nxt;
  logic signed [jet_pkg::PROD_W-1:0]  prod_rr_r, prod_ii_r, prod_ri_r;
  logic signed [jet_pkg::PROD_W-1:0]  prod_rr_nxt, prod_ii_nxt, prod_ri_nxt;
  logic        [COUNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic        [jet_pkg::OUT_W-1:0]   count_out_r;

  logic        [jet_pkg::PROD_W-1:0]  mag;
  logic        [jet_pkg::PROD_W-1:0]  mag_hi;
  logic                               mag_lo_nz;
  logic signed [jet_pkg::PROD_W-1:0]  diff;
  logic signed [jet_pkg::PROD_W-1:0]  re_full, im_full;

  // one multiply per product, registered before use
  assign prod_rr_nxt = re_r * re_r;
  assign prod_ii_nxt = im_r * im_r;
  assign prod_ri_nxt = re_r * im_r;

  // |z|^2 against threshold scaled by 2^FRAC_BITS
  assign mag       = $unsigned(prod_rr_r) + $unsigned(prod_ii_r);
  assign mag_hi    = mag >> FRAC_BITS;
  assign mag_lo_nz = |(mag & LO_MASK);

  assign sts.escaped  = (mag_hi > jet_pkg::PROD_W'(escape_sq)) ||
                        ((mag_hi == jet_pkg::PROD_W'(escape_sq)) && mag_lo_nz);
  assign sts.at_limit = (cnt_r == iter_limit);

  // arithmetic shift right gives floor
  assign diff    = prod_rr_r - prod_ii_r;
  assign re_full = (diff >>> FRAC_BITS) + jet_pkg::PROD_W'(const_real);
  assign im_full = (prod_ri_r >>> (FRAC_BITS - 1)) + jet_pkg::PROD_W'(const_imag);

  always_comb begin
    re_nxt  = re_r;
    im_nxt  = im_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      re_nxt  = start_real;
      im_nxt  = start_imag;
      cnt_nxt = '0;
    end else if (cmd.upd) begin
      re_nxt  = jet_pkg::sat_coord(re_full);
      im_nxt  = jet_pkg::sat_coord(im_full);
      cnt_nxt = cnt_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    re_r <= re_nxt;
    im_r <= im_nxt;
    if (cmd.mul) begin
      prod_rr_r <= prod_rr_nxt;
      prod_ii_r <= prod_ii_nxt;
      prod_ri_r <= prod_ri_nxt;
    end
    if (cmd.emit) begin
      count_out_r <= jet_pkg::OUT_W'(cnt_r);
    end
  end

  assign escape_count = count_out_r;

endmodule

// File: tb/julia_escape_time_checker.sv
module julia_escape_time_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [jet_pkg::COORD_W-1:0] in_start_real,
  input  logic signed [jet_pkg::COORD_W-1:0] in_start_imag,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic        [jet_pkg::OUT_W-1:0]   out_escape_count,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic        [1:0]                  cfg_index,
  input  logic        [jet_pkg::COORD_W-1:0] cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);

  localparam int FRAC = 28;

  typedef struct {
    logic signed [jet_pkg::COORD_W-1:0] re;
    logic signed [jet_pkg::COORD_W-1:0] im;
    logic        [jet_pkg::OUT_W-1:0]   count;
  } point_t;

  logic signed [jet_pkg::COORD_W-1:0] c_re;
  logic signed [jet_pkg::COORD_W-1:0] c_im;
  logic        [jet_pkg::OUT_W-1:0]   iter_limit;
  logic        [jet_pkg::ESC_W-1:0]   esc_sq;
  point_t                             escape_q[$];
  point_t                             head;
  point_t                             fresh;

  function automatic longint clamp_coord(input longint x);
    if (x > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (x < -longint'(64'h8000_0000)) return -longint'(64'h8000_0000);
    return x;
  endfunction

  // iterate z = z*z + c, testing |z|^2 against the threshold before each update
  function automatic logic [jet_pkg::OUT_W-1:0] escape_iteration(
    input logic signed [jet_pkg::COORD_W-1:0] re0,
    input logic signed [jet_pkg::COORD_W-1:0] im0
  );
    longint      re;
    longint      im;
    longint      nre;
    longint      nim;
    logic [63:0] mag;
    logic [63:0] bound;
    re    = re0;
    im    = im0;
    bound = 64'(esc_sq) << FRAC;
    for (int k = 0; k < int'(iter_limit); k++) begin
      mag = $unsigned(re * re) + $unsigned(im * im);
      if (mag > bound) return jet_pkg::OUT_W'(k);
      nre = ((re * re - im * im) >>> FRAC) + longint'(c_re);
      nim = ((re * im) >>> (FRAC - 1)) + longint'(c_im);
      re  = clamp_coord(nre);
      im  = clamp_coord(nim);
    end
    return iter_limit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("checker: %s", msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      c_re       = jet_pkg::CONST_REAL_RST;
      c_im       = jet_pkg::CONST_IMAG_RST;
      iter_limit = jet_pkg::OUT_W'(jet_pkg::LIMIT_RST);
      esc_sq     = jet_pkg::ESC_SQ_RST;
      fail_count = 0;
      escape_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (jet_pkg::cfg_reg_t'(cfg_index))
          jet_pkg::REG_CONST_REAL: c_re = cfg_wdata;
          jet_pkg::REG_CONST_IMAG: c_im = cfg_wdata;
          jet_pkg::REG_ITER_LIMIT: iter_limit = cfg_wdata[jet_pkg::OUT_W-1:0];
          jet_pkg::REG_ESC_SQUARE: esc_sq = cfg_wdata[jet_pkg::ESC_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (escape_q.size() == 0) begin
          report_mismatch($sformatf("escape_count %0d with no transaction outstanding",
                                    out_escape_count));
        end else begin
          head = escape_q.pop_front();
          if (out_escape_count !== head.count) begin
            report_mismatch($sformatf("escape_count for (%0d, %0d): got %0d, want %0d",
                                      head.re, head.im, out_escape_count, head.count));
          end
        end
      end
      if (in_valid && !in_stall) begin
        fresh.re    = in_start_real;
        fresh.im    = in_start_imag;
        fresh.count = escape_iteration(in_start_real, in_start_imag);
        escape_q.push_back(fresh);
      end
    end
    pending = escape_q.size();
  end

endmodule

// File: tb/julia_escape_time_top_tb.sv
module julia_escape_time_top_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic signed [jet_pkg::COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [jet_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [jet_pkg::COORD_W-1:0] ONE_HALF3 = 32'sd402653184; // 1.5

  logic                               clk;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic signed [jet_pkg::COORD_W-1:0] in_start_real;
  logic signed [jet_pkg::COORD_W-1:0] in_start_imag;
  logic                               out_valid;
  logic                               out_stall;
  logic        [jet_pkg::OUT_W-1:0]   out_escape_count;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic        [1:0]                  cfg_index;
  logic        [jet_pkg::COORD_W-1:0] cfg_wdata;
  int                                 fail_count;
  int                                 pending;

  logic rx_stall = 1'b0;
  logic rx_hold  = 1'b0;
  bit   quiet    = 1'b0;
  int   cycles   = 0;

  assign out_stall = rx_stall | rx_hold;

  julia_escape_time_top i_dut (.*);

  julia_escape_time_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("julia_escape_time_top_tb failed");
      $finish;
    end
  end

  // result side: random stall before each transaction
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = quiet ? 0 : $urandom_range(0, 17);
      if (n > 0) begin
        rx_stall = 1'b1;
        repeat (n) @(negedge clk);
        rx_stall = 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic write_reg(input jet_pkg::cfg_reg_t idx,
                           input logic [jet_pkg::COORD_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // upper bits beyond each register's width are randomized and must be ignored
  task automatic set_config(input logic signed [jet_pkg::COORD_W-1:0] cr,
                            input logic signed [jet_pkg::COORD_W-1:0] ci,
                            input int lim, input logic [jet_pkg::ESC_W-1:0] esc);
    write_reg(jet_pkg::REG_CONST_REAL, cr);
    write_reg(jet_pkg::REG_CONST_IMAG, ci);
    write_reg(jet_pkg::REG_ITER_LIMIT,
              (32'($urandom) & 32'hFFFF_FC00) | 32'(lim[jet_pkg::OUT_W-1:0]));
    write_reg(jet_pkg::REG_ESC_SQUARE, (32'($urandom) & 32'h8000_0000) | 32'(esc));
  endtask

  task automatic send_point(input logic signed [jet_pkg::COORD_W-1:0] re,
                            input logic signed [jet_pkg::COORD_W-1:0] im);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_start_real = re;
    in_start_imag = im;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // mostly points within +-1.5 so orbits run for a while, sometimes the full range
  function automatic logic signed [jet_pkg::COORD_W-1:0] rand_coord(input bit wide);
    if (wide) return $urandom;
    return $urandom_range(0, 805306368) - 402653184;
  endfunction

  initial begin
    logic signed [jet_pkg::COORD_W-1:0] cr;
    logic signed [jet_pkg::COORD_W-1:0] ci;
    logic        [jet_pkg::ESC_W-1:0]   esc;
    int                                 lim;
    in_valid      = 1'b0;
    in_start_real = '0;
    in_start_imag = '0;
    cfg_valid     = 1'b0;
    cfg_index     = jet_pkg::REG_CONST_REAL;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset configuration: c = -0.4 + 0.6i, limit 200, threshold 2.25
    send_point(0, 0);
    send_point(1, -1);
    send_point(C_MAX, C_MAX);
    send_point(C_MIN, C_MIN);
    send_point(C_MIN, 0);
    send_point(0, C_MAX);
    send_point(ONE_HALF3, 0);        // exactly on the threshold
    send_point(ONE_HALF3 + 1, 0);
    send_point(0, -ONE_HALF3);
    send_point(-ONE_HALF3, 0);
    send_point(26843546, -26843546);
    send_point(107374182, 53687091);
    drain();

    // zero limit: no test, result always 0
    set_config(jet_pkg::CONST_REAL_RST, jet_pkg::CONST_IMAG_RST, 0, jet_pkg::ESC_SQ_RST);
    repeat (8) send_point(rand_coord(1'($urandom_range(0, 1))),
                          rand_coord(1'($urandom_range(0, 1))));
    drain();

    // full limit with c = 0 and threshold 4.0: bounded points run all 1023 iterations
    set_config(0, 0, 1023, 31'd1073741824);
    send_point(0, 0);
    send_point(134217728, 134217728);
    send_point(268435456, 0);
    send_point(536870912, 0);        // equal to threshold, escapes one step later
    drain();

    // extreme constants and largest threshold, where coordinates saturate
    set_config(C_MIN, C_MAX, 30, 31'h7FFF_FFFF);
    repeat (8) send_point(rand_coord(1'b1), rand_coord(1'b1));
    drain();
    set_config(C_MAX, C_MIN, 30, 31'h7FFF_FFFF);
    repeat (8) send_point(rand_coord(1'($urandom_range(0, 1))), rand_coord(1'b0));
    drain();

    // zero threshold: anything nonzero escapes at once
    set_config(jet_pkg::CONST_REAL_RST, jet_pkg::CONST_IMAG_RST, 10, '0);
    send_point(0, 0);
    send_point(1, 0);
    send_point(0, -1);
    send_point(C_MIN, C_MAX);
    drain();

    // long hold-off on the result side while points keep coming
    set_config(jet_pkg::CONST_REAL_RST, jet_pkg::CONST_IMAG_RST, 6, jet_pkg::ESC_SQ_RST);
    quiet = 1'b1;
    fork
      begin
        rx_hold = 1'b1;
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (40) send_point(rand_coord(1'b0), rand_coord(1'b0));
    drain();

    for (int p = 0; p < 8; p++) begin
      cr  = $urandom_range(0, 1073741824) - 536870912;
      ci  = $urandom_range(0, 1073741824) - 536870912;
      if ($urandom_range(0, 5) == 0) cr = $urandom;
      lim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 100);
      case ($urandom_range(0, 2))
        0:       esc = jet_pkg::ESC_SQ_RST;
        1:       esc = 31'd1073741824;
        default: esc = jet_pkg::ESC_W'($urandom);
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      set_config(cr, ci, lim, esc);
      repeat (40) send_point(rand_coord($urandom_range(0, 4) == 0),
                             rand_coord($urandom_range(0, 4) == 0));
      drain();
    end

    repeat (2 * 1023 + 8) @(negedge clk);
    if (fail_count == 0) begin
      $display("julia_escape_time_top_tb passed");
    end else begin
      $display("julia_escape_time_top_tb failed");
    end
    $finish;
  end

endmodule

// File: julia_escape_time_top.f
rtl/jet_pkg.sv
rtl/jet_ctrl.sv
rtl/jet_dp.sv
rtl/julia_escape_time_top.sv
tb/julia_escape_time_checker.sv
tb/julia_escape_time_top_tb.sv
